[hw/rtl/ddsm_pkg.sv]
// ddsm_pkg: shared constants, stage control type and constant dividers
// for the differential drive slew mixer; no dependencies
package ddsm_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int IN_W          = 16;
    localparam int SUM_W         = 17;
    localparam int STEP_W        = 15;
    localparam int SL_W          = 18;
    localparam int WORK_W        = 24;
    localparam int DIV200_OUT_W  = 9;
    localparam int DIV10_IN_W    = 19;
    localparam int DIV10_OUT_W   = 16;
    localparam int RECIP_SHIFT   = 24;

    localparam logic [16:0] DIV200_MUL = 17'd83886;
    localparam logic [20:0] DIV10_MUL  = 21'd1677721;

    typedef enum logic
    {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic valid;
        logic clear;
    } stage_ctl_t;

    // floor(x / 200) by reciprocal multiply and one correction step
    function automatic logic [DIV200_OUT_W-1:0] div200(input logic [16:0] x);
        logic [33:0]             prod;
        logic [DIV200_OUT_W-1:0] q;
        logic [16:0]             r;
        prod = {17'd0, x} * {17'd0, DIV200_MUL};
        q = prod[RECIP_SHIFT +: DIV200_OUT_W];
        r = x - ({8'd0, q} * 17'd200);
        if (r >= 17'd200)
        begin
            q = q + 9'd1;
        end
        return q;
    endfunction

    // floor(x / 10) by reciprocal multiply and one correction step
    function automatic logic [DIV10_OUT_W-1:0] div10(input logic [DIV10_IN_W-1:0] x);
        logic [39:0]            prod;
        logic [DIV10_OUT_W-1:0] q;
        logic [DIV10_IN_W-1:0]  r;
        prod = {21'd0, x} * {19'd0, DIV10_MUL};
        q = prod[RECIP_SHIFT +: DIV10_OUT_W];
        r = x - ({3'd0, q} * 19'd10);
        if (r >= 19'd10)
        begin
            q = q + 16'd1;
        end
        return q;
    endfunction

endpackage

[hw/rtl/ddsm_ratio.sv]
// ddsm_ratio: forward/turn split and turn and speed ratios, one register stage
// depends on ddsm_pkg
module ddsm_ratio #(
    parameter int FRAC_BITS = ddsm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ddsm_pkg::stage_ctl_t          up_ctl,
    output logic                          up_ready,
    input  logic signed [15:0]            lt,
    input  logic signed [15:0]            rt,
    output ddsm_pkg::stage_ctl_t          dn_ctl,
    input  logic                          dn_ready,
    output logic signed [16:0]            f2,
    output logic signed [16:0]            t2,
    output logic        [FRAC_BITS:0]     tr,
    output logic        [FRAC_BITS:0]     sr
);

    localparam int ONE = 1 << FRAC_BITS;
    localparam int RW  = FRAC_BITS + 1;
    localparam int CW  = (RW > ddsm_pkg::DIV200_OUT_W) ? RW : ddsm_pkg::DIV200_OUT_W;

    ddsm_pkg::stage_ctl_t  ctl_reg;
    logic signed [16:0]    f2_reg, f2_next;
    logic signed [16:0]    t2_reg, t2_next;
    logic [FRAC_BITS:0]    tr_reg, tr_next;
    logic [FRAC_BITS:0]    sr_reg, sr_next;
    logic [16:0]           abs_f2;
    logic [16:0]           abs_t2;
    logic [CW-1:0]         tq;
    logic [CW-1:0]         sq;

    assign up_ready = !ctl_reg.valid || dn_ready;

    always_comb
    begin
        f2_next = 17'(lt) + 17'(rt);
        t2_next = 17'(lt) - 17'(rt);
        abs_f2  = f2_next[16] ? 17'(-f2_next) : 17'(f2_next);
        abs_t2  = t2_next[16] ? 17'(-t2_next) : 17'(t2_next);
        tq      = CW'(ddsm_pkg::div200(abs_t2));
        sq      = CW'(ddsm_pkg::div200(abs_f2));
        tr_next = (tq > CW'(ONE)) ? RW'(ONE) : tq[RW-1:0];
        sr_next = (sq > CW'(ONE)) ? RW'(ONE) : sq[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (up_ready)
        begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_ctl.valid)
        begin
            f2_reg <= f2_next;
            t2_reg <= t2_next;
            tr_reg <= tr_next;
            sr_reg <= sr_next;
        end
    end

    assign dn_ctl = ctl_reg;
    assign f2     = f2_reg;
    assign t2     = t2_reg;
    assign tr     = tr_reg;
    assign sr     = sr_reg;

endmodule

[hw/rtl/ddsm_scale.sv]
// ddsm_scale: throttle scaling, slew step and difference limit over three stages
// depends on ddsm_pkg
module ddsm_scale #(
    parameter int FRAC_BITS = ddsm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [14:0]                   step_base,
    input  ddsm_pkg::stage_ctl_t          up_ctl,
    output logic                          up_ready,
    input  logic signed [16:0]            f2,
    input  logic signed [16:0]            t2,
    input  logic        [FRAC_BITS:0]     tr,
    input  logic        [FRAC_BITS:0]     sr,
    output ddsm_pkg::stage_ctl_t          dn_ctl,
    input  logic                          dn_ready,
    output logic signed [17:0]            sl,
    output logic signed [17:0]            srt,
    output logic        [14:0]            step,
    output logic        [FRAC_BITS+5:0]   lim
);

    localparam int ONE  = 1 << FRAC_BITS;
    localparam int RW   = FRAC_BITS + 1;
    localparam int DIVW = ddsm_pkg::DIV10_IN_W;
    localparam int FACW = FRAC_BITS + 4;
    localparam int SPW  = ddsm_pkg::STEP_W + FACW;
    localparam int LIMW = FRAC_BITS + 6;
    localparam int FTW  = FRAC_BITS + 19;
    localparam int SUMW = FRAC_BITS + 20;
    localparam int SLW  = ddsm_pkg::SL_W;

    // throttle scale, step product and limit
    ddsm_pkg::stage_ctl_t       s3_ctl_reg;
    logic [RW-1:0]              ts_reg, ts_next;
    logic [SPW-1:0]             sprod_reg, sprod_next;
    logic [LIMW-1:0]            lim3_reg, lim_next;
    logic signed [16:0]         f2_3_reg;
    logic signed [16:0]         t2_3_reg;
    logic [ddsm_pkg::DIV10_OUT_W-1:0] tq10;
    logic [FACW-1:0]            fac;

    // scaled forward and final step
    ddsm_pkg::stage_ctl_t       s4_ctl_reg;
    logic signed [FTW-1:0]      fts_reg, fts_next;
    logic [14:0]                step4_reg, step_next;
    logic [LIMW-1:0]            lim4_reg;
    logic signed [16:0]         t2_4_reg;
    logic signed [RW:0]         ts_s;
    logic [ddsm_pkg::DIV10_OUT_W-1:0] sq10;

    // per-side scaled targets
    ddsm_pkg::stage_ctl_t       s5_ctl_reg;
    logic signed [SLW-1:0]      sl_reg, sl_next;
    logic signed [SLW-1:0]      srt_reg, srt_next;
    logic [14:0]                step5_reg;
    logic [LIMW-1:0]            lim5_reg;
    logic signed [SUMW-1:0]     sum_l;
    logic signed [SUMW-1:0]     sum_r;
    logic signed [SUMW-1:0]     turn_sh;
    logic signed [SUMW-1:0]     sh_l;
    logic signed [SUMW-1:0]     sh_r;

    logic s3_ready;
    logic s4_ready;
    logic s5_ready;

    assign s5_ready = !s5_ctl_reg.valid || dn_ready;
    assign s4_ready = !s4_ctl_reg.valid || s5_ready;
    assign s3_ready = !s3_ctl_reg.valid || s4_ready;
    assign up_ready = s3_ready;

    always_comb
    begin
        tq10       = ddsm_pkg::div10(DIVW'({tr, 2'b00}));
        ts_next    = RW'(ONE) - {1'b0, tq10[FRAC_BITS-1:0]};
        fac        = FACW'(10 * ONE) - (FACW'(tr) + FACW'({tr, 1'b0}));
        sprod_next = SPW'(step_base) * SPW'(fac);
        lim_next   = LIMW'(60 * ONE) - (LIMW'({sr, 4'b0000}) + LIMW'({sr, 2'b00}));
    end

    always_comb
    begin
        ts_s      = signed'({1'b0, ts_reg});
        fts_next  = FTW'(f2_3_reg) * FTW'(ts_s);
        sq10      = ddsm_pkg::div10(sprod_reg[FRAC_BITS +: DIVW]);
        step_next = sq10[14:0];
    end

    always_comb
    begin
        turn_sh  = SUMW'(t2_4_reg) <<< FRAC_BITS;
        sum_l    = SUMW'(fts_reg) + turn_sh;
        sum_r    = SUMW'(fts_reg) - turn_sh;
        sh_l     = sum_l >>> (FRAC_BITS + 1);
        sh_r     = sum_r >>> (FRAC_BITS + 1);
        sl_next  = sh_l[SLW-1:0];
        srt_next = sh_r[SLW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_ctl_reg <= up_ctl;
            end
            if (s4_ready)
            begin
                s4_ctl_reg <= s3_ctl_reg;
            end
            if (s5_ready)
            begin
                s5_ctl_reg <= s4_ctl_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && up_ctl.valid)
        begin
            ts_reg    <= ts_next;
            sprod_reg <= sprod_next;
            lim3_reg  <= lim_next;
            f2_3_reg  <= f2;
            t2_3_reg  <= t2;
        end
        if (s4_ready && s3_ctl_reg.valid)
        begin
            fts_reg   <= fts_next;
            step4_reg <= step_next;
            lim4_reg  <= lim3_reg;
            t2_4_reg  <= t2_3_reg;
        end
        if (s5_ready && s4_ctl_reg.valid)
        begin
            sl_reg    <= sl_next;
            srt_reg   <= srt_next;
            step5_reg <= step4_reg;
            lim5_reg  <= lim4_reg;
        end
    end

    assign dn_ctl = s5_ctl_reg;
    assign sl     = sl_reg;
    assign srt    = srt_reg;
    assign step   = step5_reg;
    assign lim    = lim5_reg;

endmodule

[hw/rtl/ddsm_slew.sv]
// ddsm_slew: slew limit against history, difference cap, clamp, brake detect
// holds the output register and the drive history; depends on ddsm_pkg
module ddsm_slew #(
    parameter int FRAC_BITS = ddsm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ddsm_pkg::stage_ctl_t          up_ctl,
    output logic                          up_ready,
    input  logic signed [17:0]            sl,
    input  logic signed [17:0]            srt,
    input  logic        [14:0]            step,
    input  logic        [FRAC_BITS+5:0]   lim,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [15:0]            left_out,
    output logic signed [15:0]            right_out,
    output logic                          brake_on,
    output logic                          mode_changed
);

    localparam int ONE = 1 << FRAC_BITS;
    localparam int WW  = ddsm_pkg::WORK_W;
    localparam logic signed [WW-1:0] HUND_W = WW'(100 * ONE);
    localparam logic signed [15:0]   ONE_S  = 16'(ONE);

    logic                valid_reg;
    logic signed [15:0]  left_reg, left_next;
    logic signed [15:0]  right_reg, right_next;
    logic                brake_reg, brake_next;
    logic                changed_reg, changed_next;
    logic                load;

    logic signed [WW-1:0] sl_w;
    logic signed [WW-1:0] sr_w;
    logic signed [WW-1:0] prev_l;
    logic signed [WW-1:0] prev_r;
    logic signed [WW-1:0] step_w;
    logic signed [WW-1:0] lim_w;
    logic signed [WW-1:0] dl;
    logic signed [WW-1:0] dr;
    logic signed [WW-1:0] lw;
    logic signed [WW-1:0] rw;
    logic signed [WW-1:0] diff;
    logic signed [WW-1:0] adj;
    logic signed [WW-1:0] l2;
    logic signed [WW-1:0] r2;

    assign up_ready = !valid_reg || !result_stall;
    assign load     = up_ready && up_ctl.valid;

    always_comb
    begin
        sl_w   = WW'(sl);
        sr_w   = WW'(srt);
        prev_l = WW'(left_reg);
        prev_r = WW'(right_reg);
        step_w = signed'(WW'(step));
        lim_w  = signed'(WW'(lim));

        dl = sl_w - prev_l;
        dr = sr_w - prev_r;
        if (dl > step_w)
        begin
            lw = prev_l + step_w;
        end
        else if (dl < -step_w)
        begin
            lw = prev_l - step_w;
        end
        else
        begin
            lw = sl_w;
        end
        if (dr > step_w)
        begin
            rw = prev_r + step_w;
        end
        else if (dr < -step_w)
        begin
            rw = prev_r - step_w;
        end
        else
        begin
            rw = sr_w;
        end

        diff = (lw - rw) >>> 1;
        adj  = '0;
        l2   = lw;
        r2   = rw;
        if (diff > lim_w)
        begin
            adj = diff - lim_w;
            l2  = lw - adj;
            r2  = rw + adj;
        end
        else if (diff < -lim_w)
        begin
            adj = -lim_w - diff;
            l2  = lw + adj;
            r2  = rw - adj;
        end

        if (l2 < -HUND_W)
        begin
            l2 = -HUND_W;
        end
        else if (l2 > HUND_W)
        begin
            l2 = HUND_W;
        end
        if (r2 < -HUND_W)
        begin
            r2 = -HUND_W;
        end
        else if (r2 > HUND_W)
        begin
            r2 = HUND_W;
        end

        if (up_ctl.clear)
        begin
            left_next    = '0;
            right_next   = '0;
            brake_next   = brake_reg;
            changed_next = 1'b0;
        end
        else
        begin
            left_next    = l2[15:0];
            right_next   = r2[15:0];
            brake_next   = (left_next > -ONE_S) && (left_next < ONE_S)
                        && (right_next > -ONE_S) && (right_next < ONE_S);
            changed_next = brake_next != brake_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
            right_reg <= '0;
            brake_reg <= 1'b1;
        end
        else
        begin
            if (up_ready)
            begin
                valid_reg <= up_ctl.valid;
            end
            if (load)
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
                brake_reg <= brake_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            changed_reg <= changed_next;
        end
    end

    assign result_valid = valid_reg;
    assign left_out     = left_reg;
    assign right_out    = right_reg;
    assign brake_on     = brake_reg;
    assign mode_changed = changed_reg;

    // clear zeroes history and never flags a mode change
    assert property (@(posedge clk) disable iff (!rst_n)
        load && up_ctl.clear |=> left_reg == '0 && right_reg == '0 && !changed_reg)
        else $error("clear did not zero history");

    // clear leaves brake mode alone
    assert property (@(posedge clk) disable iff (!rst_n)
        load && up_ctl.clear |=> brake_reg == $past(brake_reg))
        else $error("clear changed brake mode");

    // mode change flag tracks the brake mode transition
    assert property (@(posedge clk) disable iff (!rst_n)
        load && !up_ctl.clear |=> changed_reg == (brake_reg != $past(brake_reg)))
        else $error("mode change flag mismatch");

endmodule

[hw/rtl/differential_drive_slew_mixer.sv]
// differential_drive_slew_mixer: throughput one item per cycle unless stalled;
// the drive history in the output stage is the only feedback, so back-to-back
// items see each other's outputs
// stalls hold each stage; bubbles close up; the output register frees the input
// reset: history zero, brake mode on, step base 5 percent, pipeline empty
// depends on ddsm_pkg, ddsm_ratio, ddsm_scale, ddsm_slew
module differential_drive_slew_mixer #(
    parameter int FRAC_BITS = ddsm_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [14:0]          cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 opcode,
    input  logic signed [15:0]   left_target,
    input  logic signed [15:0]   right_target,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic signed [15:0]   left_out,
    output logic signed [15:0]   right_out,
    output logic                 brake_on,
    output logic                 mode_changed
);

    localparam logic [14:0] STEP_RESET = 15'(5 << FRAC_BITS);

    logic [14:0]           step_base_reg;
    ddsm_pkg::stage_ctl_t  in_ctl_reg;
    ddsm_pkg::stage_ctl_t  in_ctl_next;
    logic signed [15:0]    lt_reg;
    logic signed [15:0]    rt_reg;
    logic                  in_ready;

    ddsm_pkg::stage_ctl_t  ratio_ctl;
    logic                  ratio_ready;
    logic signed [16:0]    f2;
    logic signed [16:0]    t2;
    logic [FRAC_BITS:0]    tr;
    logic [FRAC_BITS:0]    sr;

    ddsm_pkg::stage_ctl_t  scale_ctl;
    logic                  scale_ready;
    logic signed [17:0]    sl;
    logic signed [17:0]    srt;
    logic [14:0]           step;
    logic [FRAC_BITS+5:0]  lim;

    logic                  slew_ready;

    assign cfg_ready  = 1'b1;
    assign in_ready   = !in_ctl_reg.valid || ratio_ready;
    assign item_stall = !in_ready;

    always_comb
    begin
        in_ctl_next.valid = item_valid;
        in_ctl_next.clear = (ddsm_pkg::opcode_t'(opcode) == ddsm_pkg::OP_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_base_reg <= STEP_RESET;
            in_ctl_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_base_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_ctl_reg <= in_ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && item_valid)
        begin
            lt_reg <= left_target;
            rt_reg <= right_target;
        end
    end

    ddsm_ratio #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_ctl   (in_ctl_reg),
        .up_ready (ratio_ready),
        .lt       (lt_reg),
        .rt       (rt_reg),
        .dn_ctl   (ratio_ctl),
        .dn_ready (scale_ready),
        .f2       (f2),
        .t2       (t2),
        .tr       (tr),
        .sr       (sr)
    );

    ddsm_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_base (step_base_reg),
        .up_ctl    (ratio_ctl),
        .up_ready  (scale_ready),
        .f2        (f2),
        .t2        (t2),
        .tr        (tr),
        .sr        (sr),
        .dn_ctl    (scale_ctl),
        .dn_ready  (slew_ready),
        .sl        (sl),
        .srt       (srt),
        .step      (step),
        .lim       (lim)
    );

    ddsm_slew #(
        .FRAC_BITS (FRAC_BITS)
    ) u_slew (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_ctl       (scale_ctl),
        .up_ready     (slew_ready),
        .sl           (sl),
        .srt          (srt),
        .step         (step),
        .lim          (lim),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .brake_on     (brake_on),
        .mode_changed (mode_changed)
    );

    // an empty input register never holds off a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ctl_reg.valid |-> !item_stall)
        else $error("stall with empty input register");

endmodule
